// ===== src/pwfr_pkg.sv =====
package pwfr_pkg;

	// default store geometry
	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	// window shape, fixed at three by three
	localparam int KERNEL  = 3;
	localparam int TAPS    = KERNEL * KERNEL;
	localparam int TAP_W   = 4;
	localparam int OFF_W   = 2;
	localparam int PIX_W   = 24;
	localparam int DIM_W   = 9;

	localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAPS - 1);
	localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(KERNEL - 1);

	// request codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_FETCH = 1'b1;

	// register select, taken from address bit 2
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

	// controller to datapath
	typedef struct packed {
		logic             load_center;
		logic             store_pixel;
		logic             issue;
		logic [OFF_W-1:0] off_x;
		logic [OFF_W-1:0] off_y;
		logic [TAP_W-1:0] tap;
		logic             last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic adv;
		logic rd_pend;
	} sts_t;

endpackage

// ===== src/pwfr_ram.sv =====
module pwfr_ram #(
	parameter int DATA_W = 24,
	parameter int DEPTH  = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/pwfr_ctrl.sv =====
module pwfr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_type,
	output logic          req_stall,
	input  pwfr_pkg::sts_t sts,
	output pwfr_pkg::cmd_t cmd
);

	import pwfr_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic             state_q;
	logic [OFF_W-1:0] off_x_q;
	logic [OFF_W-1:0] off_y_q;
	logic [TAP_W-1:0] tap_q;
	logic             accept;
	logic             tap_end;

	// new word only when idle and no tap still waits for its read
	assign req_stall = (state_q != ST_IDLE) || sts.rd_pend;
	assign accept    = req_valid && !req_stall;
	assign tap_end   = (tap_q == TAP_LAST);

	// commands
	always_comb begin
		cmd.load_center = accept && (req_type == REQ_FETCH);
		cmd.store_pixel = accept && (req_type == REQ_WRITE);
		cmd.issue       = (state_q == ST_RUN) && sts.adv;
		cmd.off_x       = off_x_q;
		cmd.off_y       = off_y_q;
		cmd.tap         = tap_q;
		cmd.last        = tap_end;
	end

	// sequencer: y offset inner, x offset outer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			off_x_q <= '0;
			off_y_q <= '0;
			tap_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load_center) begin
						state_q <= ST_RUN;
						off_x_q <= '0;
						off_y_q <= '0;
						tap_q   <= '0;
					end
				end
				ST_RUN: begin
					if (sts.adv) begin
						tap_q <= tap_q + TAP_W'(1);
						if (off_y_q == OFF_LAST) begin
							off_y_q <= '0;
							off_x_q <= off_x_q + OFF_W'(1);
						end else begin
							off_y_q <= off_y_q + OFF_W'(1);
						end
						if (tap_end) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/pwfr_dp.sv =====
module pwfr_dp #(
	parameter int MAX_WIDTH  = pwfr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = pwfr_pkg::MAX_HEIGHT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pwfr_pkg::cmd_t              cmd,
	output pwfr_pkg::sts_t              sts,
	input  logic [pwfr_pkg::DIM_W-1:0]  width_q,
	input  logic [pwfr_pkg::DIM_W-1:0]  height_q,
	input  logic [7:0]                  pos_x,
	input  logic [7:0]                  pos_y,
	input  logic [7:0]                  pix_red,
	input  logic [7:0]                  pix_green,
	input  logic [7:0]                  pix_blue,
	output logic                        tap_valid,
	input  logic                        tap_stall,
	output logic [pwfr_pkg::TAP_W-1:0]  tap_index,
	output logic [7:0]                  tap_red,
	output logic [7:0]                  tap_green,
	output logic [7:0]                  tap_blue,
	output logic                        last_tap
);

	import pwfr_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XCW   = $clog2(MAX_WIDTH);
	localparam int YCW   = $clog2(MAX_HEIGHT);

	// neighbour coordinate c + off - 1, clamped into [0, lim-1]
	function automatic logic [9:0] clamp_c(input logic [7:0] c, input logic [OFF_W-1:0] off,
			input logic [DIM_W-1:0] lim);
		logic [9:0] v;
		begin
			v = {2'b00, c} + 10'(off);
			if (v == 10'd0) begin
				return 10'd0;
			end
			v = v - 10'd1;
			if (v >= 10'(lim)) begin
				v = 10'(lim) - 10'd1;
			end
			return v;
		end
	endfunction

	logic [DIM_W-1:0] lim_w;
	logic [DIM_W-1:0] lim_h;
	logic [7:0]       ctr_x_q;
	logic [7:0]       ctr_y_q;
	logic             adv;

	logic             v_s1;
	logic [TAP_W-1:0] tap_s1;
	logic             last_s1;
	logic [XCW-1:0]   cx_s1;
	logic [YCW-1:0]   cy_s1;

	logic             v_s2;
	logic [TAP_W-1:0] tap_s2;
	logic             last_s2;

	logic             wr_en;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr;
	logic [PIX_W-1:0] rdata;

	logic             valid_q;
	logic [TAP_W-1:0] tap_q;
	logic [PIX_W-1:0] pix_q;
	logic             last_q;

	// active size, zero read as one, saturated at the store size
	always_comb begin
		if (width_q == '0) begin
			lim_w = DIM_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			lim_w = DIM_W'(MAX_WIDTH);
		end else begin
			lim_w = width_q;
		end
		if (height_q == '0) begin
			lim_h = DIM_W'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			lim_h = DIM_W'(MAX_HEIGHT);
		end else begin
			lim_h = height_q;
		end
	end

	// whole pipeline moves when the output register is free
	assign adv         = !valid_q || !tap_stall;
	assign sts.adv     = adv;
	assign sts.rd_pend = v_s1;

	// window centre
	always_ff @(posedge clk) begin
		if (cmd.load_center) begin
			ctr_x_q <= pos_x;
			ctr_y_q <= pos_y;
		end
	end

	// pixel write, dropped outside the store
	assign wr_en = cmd.store_pixel && (32'(pos_x) < MAX_WIDTH) && (32'(pos_y) < MAX_HEIGHT);
	assign waddr = AW'(pos_y) * AW'(MAX_WIDTH) + AW'(pos_x);

	// stage 1: clamped tap coordinates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tap_s1  <= cmd.tap;
			last_s1 <= cmd.last;
			cx_s1   <= XCW'(clamp_c(ctr_x_q, cmd.off_x, lim_w));
			cy_s1   <= YCW'(clamp_c(ctr_y_q, cmd.off_y, lim_h));
		end
	end

	// stage 2: store read
	assign raddr = AW'(cy_s1) * AW'(MAX_WIDTH) + AW'(cx_s1);

	pwfr_ram #(
		.DATA_W(PIX_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata({pix_red, pix_green, pix_blue}),
		.re   (adv),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tap_s2  <= tap_s1;
			last_s2 <= last_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tap_q  <= tap_s2;
			last_q <= last_s2;
			pix_q  <= rdata;
		end
	end

	assign tap_valid = valid_q;
	assign tap_index = tap_q;
	assign last_tap  = last_q;
	assign tap_red   = pix_q[23:16];
	assign tap_green = pix_q[15:8];
	assign tap_blue  = pix_q[7:0];

endmodule

// ===== src/pixel_window_fetch_replicate_unit.sv =====
// 3x3 window fetch from an RGB pixel store, border replicated.
// request channel (req_valid / req_stall): req_type selects a pixel write
// or a window fetch at (pos_x, pos_y). a word is taken at an edge with
// req_valid high and req_stall low.
// tap channel (tap_valid / tap_stall): a fetch returns nine words, x offset
// outer and y offset inner, last_tap marking the ninth. a write returns none.
// each tap of a fetch passes the coordinate stage, the store read and the
// output register, one tap per cycle while tap_stall is low. a write does
// not hold off the next request; the single read port of the store sets the pace.
// image_width and image_height: register port byte addresses 0 and 4, reset 256;
// the user writes them only while the block is idle; the block does not check.
// reset clears the control state only; the pixel store holds garbage until
// each pixel has been written.
// a stall on the tap side freezes the whole read pipeline in place; no tap
// is lost and the next request waits until the last read has been issued.
module pixel_window_fetch_replicate_unit #(
	parameter int MAX_WIDTH  = pwfr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = pwfr_pkg::MAX_HEIGHT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic                       req_type,
	input  logic [7:0]                 pos_x,
	input  logic [7:0]                 pos_y,
	input  logic [7:0]                 pix_red,
	input  logic [7:0]                 pix_green,
	input  logic [7:0]                 pix_blue,
	output logic                       tap_valid,
	input  logic                       tap_stall,
	output logic [pwfr_pkg::TAP_W-1:0] tap_index,
	output logic [7:0]                 tap_red,
	output logic [7:0]                 tap_green,
	output logic [7:0]                 tap_blue,
	output logic                       last_tap
);

	import pwfr_pkg::*;

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             cfg_wr;
	cmd_t             cmd;
	sts_t             sts;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default:    width_q  <= width_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			default:    prdata = '0;
		endcase
	end

	pwfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_type (req_type),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pwfr_dp #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.width_q  (width_q),
		.height_q (height_q),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pix_red  (pix_red),
		.pix_green(pix_green),
		.pix_blue (pix_blue),
		.tap_valid(tap_valid),
		.tap_stall(tap_stall),
		.tap_index(tap_index),
		.tap_red  (tap_red),
		.tap_green(tap_green),
		.tap_blue (tap_blue),
		.last_tap (last_tap)
	);

	// the last flag sits on the ninth tap only
	a_last_on_ninth: assert property (@(posedge clk) disable iff (!arst_n)
		tap_valid |-> (last_tap == (tap_index == TAP_LAST)))
		else $error("last_tap does not match tap index");

	// taps of one fetch follow each other without gaps, in order
	a_taps_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		tap_valid && !tap_stall && !last_tap |=>
			tap_valid && (tap_index == $past(tap_index) + TAP_W'(1)))
		else $error("tap sequence broken");

	// no request is taken while taps are still being issued
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> req_stall)
		else $error("request taken during a fetch");

endmodule
